// ===== design/fpr_pkg.sv =====
// Shared types, constants and helpers for the fixed-point image rotator.
// No dependencies; every other design file imports this package.
package fpr_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int AW = (XB - 1) + (YB - 1);

    localparam int DW = 38;
    localparam int SW = 40;
    localparam int RW = 52;
    localparam int CW = 37;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_FILL   = 3'd1;
    localparam logic [2:0] CFG_SIN    = 3'd2;
    localparam logic [2:0] CFG_COS    = 3'd3;
    localparam logic [2:0] CFG_SRC_W  = 3'd4;
    localparam logic [2:0] CFG_SRC_H  = 3'd5;
    localparam logic [2:0] CFG_STEP_X = 3'd6;
    localparam logic [2:0] CFG_STEP_Y = 3'd7;

    localparam logic [1:0] CROP_CROP   = 2'd0;
    localparam logic [1:0] CROP_NOCROP = 2'd1;
    localparam logic [1:0] CROP_FIT    = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        fill;
        logic signed [10:0] sin_q9;
        logic signed [10:0] cos_q9;
        logic [8:0]         src_w;
        logic [8:0]         src_h;
        logic [24:0]        step_x;
        logic [24:0]        step_y;
    } t_cfg;

    typedef struct packed {
        logic                 load;
        logic                 we;
        logic [31:0]          wdata;
        logic [1:0]           wbank;
        logic [AW-1:0]        waddr;
        logic [3:0][AW-1:0]   raddr;
        logic [3:0]           inb;
        logic [3:0][15:0]     wt;
        logic                 bil;
        logic                 xp;
        logic                 yp;
    } t_mem_req;

    typedef struct packed {
        logic [3:0][31:0] data;
        logic [3:0]       inb;
        logic [3:0][15:0] wt;
        logic             bil;
        logic             xp;
        logic             yp;
    } t_blend_in;

    function automatic logic [11:0] sum_abs(logic signed [10:0] a, logic signed [10:0] b);
        logic [10:0] aa;
        logic [10:0] ab;
        aa = a[10] ? 11'(-a) : 11'(a);
        ab = b[10] ? 11'(-b) : 11'(b);
        return 12'(aa) + 12'(ab);
    endfunction

endpackage

// ===== design/fpr_recip.sv =====
// Bit-serial reciprocal 131072 / max(m,1) used by fit scaling.
// Depends on fpr_pkg.
module fpr_recip import fpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [11:0] i_m,
    output logic        o_busy,
    output logic [17:0] o_recip
);

    logic [4:0]  r_cnt;
    logic [11:0] r_d;
    logic [11:0] r_rem;
    logic [16:0] r_q;
    logic [17:0] r_f;
    logic [12:0] w_trial;
    logic        w_qb;
    logic [12:0] w_diff;

    always_comb begin
        w_trial = {r_rem, (r_cnt == 5'd18)};
        w_qb    = w_trial >= {1'b0, r_d};
        w_diff  = w_trial - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_f   <= 18'd256;
        end else if (i_start) begin
            r_cnt <= 5'd18;
        end else if (r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_f <= {r_q, w_qb};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= (i_m == 12'd0) ? 12'd1 : i_m;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_cnt != 5'd0) begin
            r_rem <= w_qb ? w_diff[11:0] : w_trial[11:0];
            r_q   <= {r_q[15:0], w_qb};
        end
    end

    assign o_busy  = i_start || (r_cnt != 5'd0);
    assign o_recip = r_f;

endmodule

// ===== design/fpr_geom.sv =====
// Address pipeline: scale, crop and rotate the destination position, then
// form bank addresses, bounds flags and bilinear weights. Depends on fpr_pkg.
module fpr_geom import fpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic        i_action,
    input  logic [11:0] i_column,
    input  logic [11:0] i_row,
    input  logic [31:0] i_pixel_in,
    input  t_cfg        i_cfg,
    input  logic [11:0] i_m,
    input  logic [17:0] i_recip,
    output logic        o_req_valid,
    output t_mem_req    o_req
);

    typedef struct packed {
        logic        load;
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] pix;
    } t_tag;

    logic [5:0] r_v;
    t_tag       r_t [6];

    logic [36:0]          r_p  [2];
    logic signed [DW-1:0] r_dx [2];
    logic signed [29:0]   r_sh [2];
    logic signed [42:0]   r_nc [2];
    logic signed [40:0]   r_fh [2];
    logic [33:0]          r_fl [2];
    logic signed [SW-1:0] r_s  [2];
    logic signed [50:0]   r_cs [2];
    logic signed [50:0]   r_ss [2];
    logic signed [RW-1:0] r_r  [2];

    logic        r_req_v;
    t_mem_req    r_req;

    logic [11:0]          w_coord [2];
    logic [24:0]          w_step  [2];
    logic [8:0]           w_size  [2];
    logic [1:0]           w_crop;
    logic signed [SW-1:0] n_s  [2];
    logic signed [RW-1:0] n_r  [2];
    logic signed [41:0]   w_fsum [2];
    logic signed [51:0]   w_tx;
    logic signed [51:0]   w_ty;
    logic signed [RW-1:0] w_rn [2];
    logic signed [CW-1:0] w_c0 [2];
    logic signed [CW-1:0] w_c  [2][2];
    logic                 w_ok [2][2];
    logic [15:0]          w_f  [2];
    logic [15:0]          w_g  [2];
    logic [3:0][AW-1:0]   w_haddr;
    logic [31:0]          w_w  [4];
    t_mem_req             n_req;

    always_comb begin
        w_coord[0] = i_column;
        w_coord[1] = i_row;
        w_step[0]  = i_cfg.step_x;
        w_step[1]  = i_cfg.step_y;
        w_size[0]  = i_cfg.src_w;
        w_size[1]  = i_cfg.src_h;
        w_crop     = i_cfg.mode[2:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_req_v <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[4:0], i_valid};
            r_req_v <= r_v[5];
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_fsum[l] = 42'(r_fh[l]) + 42'($signed({1'b0, r_fl[l][33:16]}));
            unique case (w_crop)
                CROP_NOCROP: n_s[l] = SW'($signed(r_nc[l][42:9]));
                CROP_FIT:    n_s[l] = SW'(w_fsum[l]);
                default:     n_s[l] = SW'(r_sh[l]);
            endcase
        end
        w_tx   = 52'(r_cs[0]) + 52'(r_ss[1]);
        w_ty   = 52'(r_cs[1]) - 52'(r_ss[0]);
        n_r[0] = (w_tx >>> 1) + $signed({28'd0, i_cfg.src_w, 15'd0});
        n_r[1] = (w_ty >>> 1) + $signed({28'd0, i_cfg.src_h, 15'd0});
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_rn[l] = r_r[l] + 52'sd32768;
            if (r_t[5].load) begin
                w_c0[l] = $signed(CW'(l == 0 ? r_t[5].col : r_t[5].row));
            end else if (i_cfg.mode[0]) begin
                w_c0[l] = CW'($signed(r_r[l][RW-1:16]));
            end else begin
                w_c0[l] = CW'($signed(w_rn[l][RW-1:16]));
            end
            w_f[l] = r_r[l][15:0];
            w_g[l] = 16'hFFFF - w_f[l];
            for (int j = 0; j < 2; j++) begin
                w_c[l][j]  = w_c0[l] + CW'(j);
                w_ok[l][j] = !w_c[l][j][CW-1]
                    && (w_c[l][j] < $signed({{(CW-9){1'b0}}, w_size[l]}))
                    && (w_c[l][j] < $signed(CW'(l == 0 ? MAX_WIDTH : MAX_HEIGHT)));
            end
        end
        for (int k = 0; k < 4; k++) begin
            w_haddr[k] = {w_c[1][k/2][YB-1:1], w_c[0][k%2][XB-1:1]};
        end
        w_w[0] = w_g[0] * w_g[1];
        w_w[1] = w_f[0] * w_g[1];
        w_w[2] = w_g[0] * w_f[1];
        w_w[3] = w_f[0] * w_f[1];

        n_req.load  = r_t[5].load;
        n_req.we    = (r_t[5].col < 12'(MAX_WIDTH)) && (r_t[5].row < 12'(MAX_HEIGHT));
        n_req.wdata = r_t[5].pix;
        n_req.wbank = {r_t[5].row[0], r_t[5].col[0]};
        n_req.waddr = w_haddr[0];
        n_req.xp    = w_c0[0][0];
        n_req.yp    = w_c0[1][0];
        n_req.bil   = i_cfg.mode[0];
        for (int b = 0; b < 4; b++) begin
            n_req.raddr[b] = w_haddr[{b[1] ^ w_c0[1][0], b[0] ^ w_c0[0][0]}];
            n_req.inb[b]   = w_ok[0][b%2] && w_ok[1][b/2];
            n_req.wt[b]    = w_w[b][31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0] <= '{load: !i_action, col: i_column, row: i_row, pix: i_pixel_in};
            for (int i = 1; i < 6; i++) begin
                r_t[i] <= r_t[i-1];
            end
            for (int l = 0; l < 2; l++) begin
                r_p[l]  <= 37'(w_coord[l]) * 37'(w_step[l]);
                r_dx[l] <= $signed({1'b0, r_p[l]}) - $signed({14'd0, w_size[l], 15'd0});
                r_sh[l] <= $signed(r_dx[l][DW-1:8]);
                r_nc[l] <= $signed(r_dx[l][DW-1:8]) * $signed({1'b0, i_m});
                r_fh[l] <= $signed(r_dx[l][DW-1:16]) * $signed({1'b0, i_recip});
                r_fl[l] <= 34'(r_dx[l][15:0]) * 34'(i_recip);
                r_s[l]  <= n_s[l];
                r_cs[l] <= r_s[l] * i_cfg.cos_q9;
                r_ss[l] <= r_s[l] * i_cfg.sin_q9;
                r_r[l]  <= n_r[l];
            end
            r_req <= n_req;
        end
    end

    assign o_req_valid = r_req_v;
    assign o_req       = r_req;

endmodule

// ===== design/fpr_store.sv =====
// Parity-banked frame store: four banks give the 2x2 neighborhood in one read.
// Depends on fpr_pkg.
module fpr_store import fpr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_mem_req  i_req,
    output logic      o_valid,
    output t_blend_in o_data
);

    logic             r_v;
    logic [3:0][31:0] r_rd;
    logic [3:0]       r_inb;
    logic [3:0][15:0] r_wt;
    logic             r_bil;
    logic             r_xp;
    logic             r_yp;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [31:0] r_mem [2**AW];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_valid && i_req.load && i_req.we && (i_req.wbank == 2'(b))) begin
                    r_mem[i_req.waddr] <= i_req.wdata;
                end
                r_rd[b] <= r_mem[i_req.raddr[b]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid && !i_req.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inb <= i_req.inb;
            r_wt  <= i_req.wt;
            r_bil <= i_req.bil;
            r_xp  <= i_req.xp;
            r_yp  <= i_req.yp;
        end
    end

    assign o_valid = r_v;
    assign o_data  = '{data: r_rd, inb: r_inb, wt: r_wt, bil: r_bil, xp: r_xp, yp: r_yp};

endmodule

// ===== design/fpr_blend.sv =====
// Neighbor select with fill color, per-byte bilinear products and sums,
// and the output register. Depends on fpr_pkg.
module fpr_blend import fpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_blend_in   i_in,
    input  logic [31:0] i_fill,
    output logic        o_valid,
    output logic [31:0] o_pixel_out
);

    logic        r_iv;
    logic [23:0] r_prod [4][4];
    logic [31:0] r_p0;
    logic        r_bil;
    logic        r_ov;
    logic [31:0] r_pix;

    logic [31:0] w_p [4];
    logic [25:0] w_sum [4];
    logic [31:0] n_pix;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_p[k] = i_in.inb[k] ? i_in.data[{k[1] ^ i_in.yp, k[0] ^ i_in.xp}] : i_fill;
        end
        for (int b = 0; b < 4; b++) begin
            w_sum[b] = 26'(r_prod[b][0]) + 26'(r_prod[b][1])
                     + 26'(r_prod[b][2]) + 26'(r_prod[b][3]);
            n_pix[8*b +: 8] = w_sum[b][23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_iv <= i_valid;
            r_ov <= r_iv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int b = 0; b < 4; b++) begin
                for (int k = 0; k < 4; k++) begin
                    r_prod[b][k] <= 24'(w_p[k][8*b +: 8]) * 24'(i_in.wt[k]);
                end
            end
            r_p0  <= w_p[0];
            r_bil <= i_in.bil;
            r_pix <= r_bil ? n_pix : r_p0;
        end
    end

    assign o_valid     = r_ov;
    assign o_pixel_out = r_pix;

endmodule

// ===== design/fixed_point_image_rotator.sv =====
// Throughput: one word per cycle through a ten-stage pipeline that stalls as a
// whole; a write to sin or cos holds off input while the fit reciprocal is
// formed one quotient bit per cycle.
// Reset clears pipeline valids and the config registers; pipeline data and frame store contents are undefined.
module fixed_point_image_rotator import fpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [11:0] i_column,
    input  logic [11:0] i_row,
    input  logic [31:0] i_pixel_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pixel_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        r_div_start;
    logic        w_en;
    logic        w_busy;
    logic [11:0] w_m;
    logic [17:0] w_recip;
    logic        w_req_v;
    t_mem_req    w_req;
    logic        w_bl_v;
    t_blend_in   w_bl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: 3'd0, fill: 32'd0, sin_q9: 11'sd0, cos_q9: 11'sd512,
                       src_w: 9'd256, src_h: 9'd256,
                       step_x: 25'd65536, step_y: 25'd65536};
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= i_cfg_we && ((i_cfg_idx == CFG_SIN) || (i_cfg_idx == CFG_COS));
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:   r_cfg.mode   <= i_cfg_data[2:0];
                    CFG_FILL:   r_cfg.fill   <= i_cfg_data;
                    CFG_SIN:    r_cfg.sin_q9 <= $signed(i_cfg_data[10:0]);
                    CFG_COS:    r_cfg.cos_q9 <= $signed(i_cfg_data[10:0]);
                    CFG_SRC_W:  r_cfg.src_w  <= i_cfg_data[8:0];
                    CFG_SRC_H:  r_cfg.src_h  <= i_cfg_data[8:0];
                    CFG_STEP_X: r_cfg.step_x <= i_cfg_data[24:0];
                    CFG_STEP_Y: r_cfg.step_y <= i_cfg_data[24:0];
                    default:    r_cfg.mode   <= r_cfg.mode;
                endcase
            end
        end
    end

    assign w_m     = sum_abs(r_cfg.sin_q9, r_cfg.cos_q9);
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en || w_busy;

    fpr_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_m     (w_m),
        .o_busy  (w_busy),
        .o_recip (w_recip)
    );

    fpr_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_valid && !w_busy),
        .i_action    (i_action),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_pixel_in  (i_pixel_in),
        .i_cfg       (r_cfg),
        .i_m         (w_m),
        .i_recip     (w_recip),
        .o_req_valid (w_req_v),
        .o_req       (w_req)
    );

    fpr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_req_v),
        .i_req   (w_req),
        .o_valid (w_bl_v),
        .o_data  (w_bl)
    );

    fpr_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_bl_v),
        .i_in        (w_bl),
        .i_fill      (r_cfg.fill),
        .o_valid     (o_valid),
        .o_pixel_out (o_pixel_out)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for fixed_point_image_rotator: loads small source images,
// fetches rotated pixels under many register settings and checks each result word.
// Depends on fpr_pkg and the fixed_point_image_rotator RTL.
class rotator_scoreboard;
    logic [2:0]         mode;
    logic [31:0]        fill;
    logic signed [10:0] sin_q9;
    logic signed [10:0] cos_q9;
    logic [8:0]         src_w;
    logic [8:0]         src_h;
    logic [24:0]        step_x;
    logic [24:0]        step_y;
    logic [31:0]        frame[65536];
    logic [31:0]        expected_pixels[$];
    int                 errors;

    function new();
        mode = 0; fill = 0; sin_q9 = 0; cos_q9 = 512;
        src_w = 256; src_h = 256; step_x = 65536; step_y = 65536;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            fpr_pkg::CFG_MODE:   mode   = data[2:0];
            fpr_pkg::CFG_FILL:   fill   = data;
            fpr_pkg::CFG_SIN:    sin_q9 = data[10:0];
            fpr_pkg::CFG_COS:    cos_q9 = data[10:0];
            fpr_pkg::CFG_SRC_W:  src_w  = data[8:0];
            fpr_pkg::CFG_SRC_H:  src_h  = data[8:0];
            fpr_pkg::CFG_STEP_X: step_x = data[24:0];
            default:             step_y = data[24:0];
        endcase
    endfunction

    function logic [31:0] source_at(longint x, longint y);
        if (x < 0 || y < 0 || x >= src_w || y >= src_h ||
            x >= fpr_pkg::MAX_WIDTH || y >= fpr_pkg::MAX_HEIGHT)
            return fill;
        return frame[y * fpr_pkg::MAX_WIDTH + x];
    endfunction

    function logic [31:0] bilinear(longint rx, longint ry);
        logic [31:0] p[4];
        int unsigned w[4];
        int unsigned fx, fy, gx, gy, acc;
        logic [31:0] res;
        longint ix, iy;
        ix = rx >>> 16;
        iy = ry >>> 16;
        fx = rx[15:0];
        fy = ry[15:0];
        gx = 65535 - fx;
        gy = 65535 - fy;
        p[0] = source_at(ix, iy);
        p[1] = source_at(ix + 1, iy);
        p[2] = source_at(ix, iy + 1);
        p[3] = source_at(ix + 1, iy + 1);
        w[0] = (gx * gy) >> 16;
        w[1] = (fx * gy) >> 16;
        w[2] = (gx * fy) >> 16;
        w[3] = (fx * fy) >> 16;
        res = 0;
        for (int b = 0; b < 4; b++) begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += ((p[k] >> (8 * b)) & 8'hFF) * w[k];
            res |= ((acc >> 16) & 8'hFF) << (8 * b);
        end
        return res;
    endfunction

    function void note_word(logic action, logic [11:0] col, logic [11:0] row,
                            logic [31:0] pix);
        longint midx, midy, dx, dy, sx, sy, rx, ry, m, f, s, c;
        if (!action) begin
            if (col < fpr_pkg::MAX_WIDTH && row < fpr_pkg::MAX_HEIGHT)
                frame[row * fpr_pkg::MAX_WIDTH + col] = pix;
            return;
        end
        s = sin_q9;
        c = cos_q9;
        midx = 32768 * longint'(src_w);
        midy = 32768 * longint'(src_h);
        dx = longint'(col) * longint'(step_x) - midx;
        dy = longint'(row) * longint'(step_y) - midy;
        m = (s < 0 ? -s : s) + (c < 0 ? -c : c);
        if (mode[2:1] == fpr_pkg::CROP_NOCROP) begin
            sx = ((dx >>> 8) * m) >>> 9;
            sy = ((dy >>> 8) * m) >>> 9;
        end else if (mode[2:1] == fpr_pkg::CROP_FIT) begin
            f = 131072 / (m == 0 ? 1 : m);
            sx = (dx * f) >>> 16;
            sy = (dy * f) >>> 16;
        end else begin
            sx = dx >>> 8;
            sy = dy >>> 8;
        end
        rx = ((c * sx + s * sy) >>> 1) + midx;
        ry = ((-s * sx + c * sy) >>> 1) + midy;
        if (mode[0])
            expected_pixels.push_back(bilinear(rx, ry));
        else
            expected_pixels.push_back(source_at((rx + 32768) >>> 16, (ry + 32768) >>> 16));
    endfunction

    function void check_pixel(logic [31:0] got);
        logic [31:0] want;
        if (expected_pixels.size() == 0) begin
            $error("pixel_out: unexpected word %h", got);
            errors++;
            return;
        end
        want = expected_pixels.pop_front();
        if (got !== want) begin
            $error("pixel_out: expected %h, actual %h", want, got);
            errors++;
        end
    endfunction
endclass

module testbench;
    import fpr_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [11:0] i_column;
    logic [11:0] i_row;
    logic [31:0] i_pixel_in;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_pixel_out;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    rotator_scoreboard sb = new();
    int burst_left;
    int stall_left;
    int stall_kind;
    int stall_cnt;
    int cycles;

    fixed_point_image_rotator dut (.*);

    initial i_clk = 0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_word(i_action, i_column, i_row, i_pixel_in);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_pixel(o_pixel_out);
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_cnt++;
        case (stall_kind)
            0: i_stall <= 0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= stall_cnt[2];
        endcase
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 1000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task send_word(logic action, logic [11:0] col, logic [11:0] row, logic [31:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_valid    <= 1;
        i_action   <= action;
        i_column   <= col;
        i_row      <= row;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.expected_pixels.size() > 0) @(posedge i_clk);
        repeat (14) @(posedge i_clk);
    endtask

    task write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    function logic [31:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    task run_phase(logic [2:0] mode, logic [31:0] fill, int sn, int cs, int w, int h,
                   int sx, int sy, int fetches);
        int cols, rows, span_c, span_r;
        drain();
        write_reg(CFG_MODE, mode);
        write_reg(CFG_FILL, fill);
        write_reg(CFG_SIN, sn);
        write_reg(CFG_COS, cs);
        write_reg(CFG_SRC_W, w);
        write_reg(CFG_SRC_H, h);
        write_reg(CFG_STEP_X, sx);
        write_reg(CFG_STEP_Y, sy);
        cols = (w > MAX_WIDTH) ? MAX_WIDTH : w;
        rows = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                send_word(0, c, r, rand_pixel());
        send_word(0, 12'hFFF, 12'hFFF, $urandom);
        send_word(0, MAX_WIDTH, 0, $urandom);
        send_word(0, 0, MAX_HEIGHT, $urandom);
        send_word(1, 0, 0, 0);
        send_word(1, 12'hFFF, 12'hFFF, 0);
        send_word(1, 12'hFFF, 0, 0);
        send_word(1, 0, 12'hFFF, 0);
        span_c = 2 * cols + 4;
        span_r = 2 * rows + 4;
        for (int i = 0; i < fetches; i++) begin
            case ($urandom_range(0, 9))
                0: send_word(0, $urandom_range(MAX_WIDTH, 4095), $urandom, $urandom);
                1: send_word(0, $urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
                             $urandom);
                2: send_word(1, $urandom, $urandom, $urandom);
                default: send_word(1, $urandom_range(0, span_c), $urandom_range(0, span_r),
                                   $urandom);
            endcase
        end
    endtask

    initial begin
        int w, h, sn, cs, sx, sy;
        i_rst_n = 0; i_valid = 0; i_action = 0; i_column = 0; i_row = 0;
        i_pixel_in = 0; i_stall = 0; i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        burst_left = 0; stall_left = 0; stall_kind = 0; stall_cnt = 0; cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        run_phase(0, 32'h0, 0, 512, 4, 4, 65536, 65536, 4);
        run_phase(1, 32'hFFFFFFFF, -512, 0, 5, 3, 32768, 98304, 4);
        run_phase(2, 32'h12345678, 362, 362, 6, 6, 65536, 65536, 4);
        run_phase(3, 32'hA5A5A5A5, -362, 362, 6, 6, 65536, 65536, 4);
        run_phase(4, 32'h5A5A5A5A, 0, 0, 3, 3, 65536, 65536, 2);
        run_phase(5, 32'hFFFFFFFF, 512, -512, 4, 4, 16777216, 0, 2);
        run_phase(6, 32'h0F0F0F0F, 200, -470, 4, 4, 0, 16777216, 2);
        run_phase(7, 32'hF0F0F0F0, -470, -200, 4, 4, 65536, 65536, 2);
        run_phase(1, 32'hCAFEF00D, 0, 512, 0, 0, 65536, 65536, 2);
        run_phase(1, 32'h01020304, 100, 500, 256, 1, 65536, 65536, 10);
        run_phase(0, 32'h01020304, -100, 500, 1, 256, 65536, 65536, 10);
        run_phase(1, 32'h11223344, 0, 512, 300, 1, 65536, 65536, 10);

        for (int p = 0; p < 4; p++) begin
            w  = $urandom_range(1, 12);
            h  = $urandom_range(1, 12);
            sn = $urandom_range(0, 1024) - 512;
            cs = $urandom_range(0, 1024) - 512;
            sx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16777216)
                                             : $urandom_range(16384, 262144);
            sy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16777216)
                                             : $urandom_range(16384, 262144);
            run_phase($urandom_range(0, 7), $urandom, sn, cs, w, h, sx, sy, 30);
        end

        drain();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
